// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the histogram core modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock, off while reset is asserted
`define SCAH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define SCAH_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/scah_pkg.sv =====
// shared types, constants and threshold functions of the angle histogram core
`timescale 1ns / 1ps
package scah_pkg;

	localparam int NUM_BINS_DEF = 16;
	localparam int BIN_W = 6;

	localparam logic [63:0] HALF_PI_Q60 = 64'd1811004864467518433;
	localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;

	localparam logic [1:0] MODE_IN_OUT = 2'd0;
	localparam logic [1:0] MODE_IN_ONLY = 2'd1;

	typedef enum logic [1:0] {
		REG_ACCEPT_MODE,
		REG_OUTER_RADIUS,
		REG_SURFACE_TOL,
		REG_REPORT_PERIOD
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] accept_mode;
		logic [22:0] outer_radius;
		logic [15:0] surface_tolerance;
		logic [23:0] report_period;
	} cfg_t;

	typedef struct packed {
		logic on_boundary;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic signed [23:0] mom_x;
		logic signed [23:0] mom_y;
		logic signed [23:0] mom_z;
	} item_t;

	typedef struct packed {
		logic hit;
		logic [BIN_W-1:0] bin;
	} res_t;

	typedef enum logic [4:0] {
		G_IDLE, G_LO, G_HI,
		G_P2A, G_P2B, G_P2C,
		G_M2A, G_M2B, G_M2C,
		G_DTA, G_DTB, G_DTC,
		G_DDA, G_DDB, G_DDC,
		G_PMA, G_PMB, G_PMC, G_PMD,
		G_KA, G_KB, G_KC,
		G_DONE
	} geom_state_t;

	typedef enum logic [2:0] {
		H_IDLE, H_RMW, H_DRD, H_DCAP, H_DWAIT
	} hist_state_t;

	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = 128'(a) * 128'(b);
		return p[123:60];
	endfunction

	// cos^2 of a Q60 angle as unsigned Q32, Taylor series of cos up to the x^24 term
	function automatic logic [31:0] cos2_q32(input logic [63:0] theta);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] c;
		logic [63:0] c2;
		logic [64:0] t;
		logic signed [65:0] sum;
		x2 = mul_q60(theta, theta);
		term = ONE_Q60;
		sum = $signed({2'b00, ONE_Q60});
		term = mul_q60(term, x2) / 64'd2;   sum = sum - $signed({2'b00, term});
		term = mul_q60(term, x2) / 64'd12;  sum = sum + $signed({2'b00, term});
		term = mul_q60(term, x2) / 64'd30;  sum = sum - $signed({2'b00, term});
		term = mul_q60(term, x2) / 64'd56;  sum = sum + $signed({2'b00, term});
		term = mul_q60(term, x2) / 64'd90;  sum = sum - $signed({2'b00, term});
		term = mul_q60(term, x2) / 64'd132; sum = sum + $signed({2'b00, term});
		term = mul_q60(term, x2) / 64'd182; sum = sum - $signed({2'b00, term});
		term = mul_q60(term, x2) / 64'd240; sum = sum + $signed({2'b00, term});
		term = mul_q60(term, x2) / 64'd306; sum = sum - $signed({2'b00, term});
		term = mul_q60(term, x2) / 64'd380; sum = sum + $signed({2'b00, term});
		term = mul_q60(term, x2) / 64'd462; sum = sum - $signed({2'b00, term});
		term = mul_q60(term, x2) / 64'd552; sum = sum + $signed({2'b00, term});
		c = (sum < 0) ? 64'd0 : sum[63:0];
		if (c > ONE_Q60)
			c = ONE_Q60;
		c2 = mul_q60(c, c);
		t = ({1'b0, c2} + 65'd134217728) >> 28;
		return (t > 65'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
	endfunction

endpackage

// ===== rtl/core/sphere_crossing_angle_histogram_core.sv =====
// top level of the sphere crossing angle histogram core
// a step that is not a candidate goes straight to its result; a candidate runs the
// radius test on the squared band edges, position and momentum and, if it passes,
// walks the bin thresholds one by one, all on one shared 33x33 multiply-accumulate unit,
// then a read-modify-write update of the bin memory
// throughput: one step at a time through that unit; a dump reads one bin at a time
// (read, capture, wait for output ready) over the bin memory's single read port
// reset: clears bins (per-bin valid flags), peak and period counter, and sets registers to defaults at once
`timescale 1ns / 1ps
module sphere_crossing_angle_histogram_core import scah_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [23:0]  cfg_wdata,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x, pos_y, pos_z, mom_x, mom_y, mom_z
	input  logic [143:0] s_tdata,
	// on_boundary
	input  logic         s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// bin_index, bin_count, peak_count, two zero bits
	output logic [71:0]  m_tdata,
	output logic         m_tlast
);

	cfg_t cfg_q;
	item_t item;
	res_t res;
	logic res_valid, res_ready;
	logic [BIN_W-1:0] out_index;
	logic [31:0] out_count, out_peak;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accept_mode <= 2'd0;
			cfg_q.outer_radius <= 23'd1000000;
			cfg_q.surface_tolerance <= 16'd1;
			cfg_q.report_period <= 24'd100000;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ACCEPT_MODE:   cfg_q.accept_mode <= cfg_wdata[1:0];
				REG_OUTER_RADIUS:  cfg_q.outer_radius <= cfg_wdata[22:0];
				REG_SURFACE_TOL:   cfg_q.surface_tolerance <= cfg_wdata[15:0];
				REG_REPORT_PERIOD: cfg_q.report_period <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		item.on_boundary = s_tuser;
		item.pos_x = s_tdata[23:0];
		item.pos_y = s_tdata[47:24];
		item.pos_z = s_tdata[71:48];
		item.mom_x = s_tdata[95:72];
		item.mom_y = s_tdata[119:96];
		item.mom_z = s_tdata[143:120];
	end

	scah_geom #(.NUM_BINS(NUM_BINS)) u_geom (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.item      (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	scah_hist #(.NUM_BINS(NUM_BINS)) u_hist (
		.clk           (clk),
		.arst_n        (arst_n),
		.report_period (cfg_q.report_period),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.out_index     (out_index),
		.out_count     (out_count),
		.out_peak      (out_peak),
		.out_last      (m_tlast)
	);

	assign m_tdata = {2'b00, out_peak, out_count, out_index};

endmodule

// ===== rtl/core/scah_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module scah_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/scah_geom.sv =====
// hit test and angle binning on a shared multiply-accumulate unit
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scah_geom import scah_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t item,
	output logic  res_valid,
	input  logic  res_ready,
	output res_t  res
);

	localparam int AW = $clog2(NUM_BINS);

	typedef struct packed {
		logic signed [32:0] a;
		logic signed [32:0] b;
		logic [6:0] sh;
		logic clr;
	} mul_op_t;

	function automatic logic signed [32:0] z33(input logic [31:0] v);
		return $signed({1'b0, v});
	endfunction

	// squared cosine thresholds, bin 0 entry is never compared
	logic [31:0] cos2_tab [NUM_BINS];
	assign cos2_tab[0] = 32'hFFFF_FFFF;
	for (genvar k = 1; k < NUM_BINS; k++) begin : g_tab
		localparam logic [127:0] KH = 128'(HALF_PI_Q60) * 128'(k);
		localparam logic [127:0] THETA_W = KH / NUM_BINS;
		assign cos2_tab[k] = cos2_q32(THETA_W[63:0]);
	end

	geom_state_t state_q, state_d;
	item_t item_q;
	logic signed [128:0] acc_q;
	logic signed [128:0] acc_next;
	logic signed [65:0] prod;
	logic [47:0] lo2_q, hi2_q, p2_q, m2_q, ad_q;
	logic [95:0] d_q, pm_q;
	logic [AW-1:0] k_q, bin_q;
	logic hit_q;
	mul_op_t op;

	logic [22:0] lo_edge;
	logic [23:0] hi_sum;
	logic [31:0] thr;
	logic eligible;
	logic reject;
	logic cmp_le;
	logic signed [48:0] dot_v;
	logic [48:0] dot_neg;

	assign lo_edge = (cfg.outer_radius >= 23'(cfg.surface_tolerance)) ?
		cfg.outer_radius - 23'(cfg.surface_tolerance) :
		23'(cfg.surface_tolerance) - cfg.outer_radius;
	assign hi_sum = 24'(cfg.outer_radius) + 24'(cfg.surface_tolerance);
	assign thr = cos2_tab[k_q];
	assign eligible = item.on_boundary &&
		(cfg.accept_mode == MODE_IN_OUT || cfg.accept_mode == MODE_IN_ONLY);

	assign prod = op.a * op.b;
	assign acc_next = (op.clr ? 129'sd0 : acc_q) + (129'(prod) <<< op.sh);

	assign reject = (acc_next[47:0] == 48'd0) || !(p2_q > lo2_q && p2_q < hi2_q);
	assign cmp_le = {d_q, 32'h0} <= acc_next[127:0];
	assign dot_v = acc_next[48:0];
	assign dot_neg = -dot_v;

	// operand selection per step
	always_comb begin
		op = '0;
		unique case (state_q)
			G_LO:  op = '{z33(32'(lo_edge)), z33(32'(lo_edge)), 7'd0, 1'b1};
			G_HI:  op = '{z33(32'(hi_sum)), z33(32'(hi_sum)), 7'd0, 1'b1};
			G_P2A: op = '{33'(item_q.pos_x), 33'(item_q.pos_x), 7'd0, 1'b1};
			G_P2B: op = '{33'(item_q.pos_y), 33'(item_q.pos_y), 7'd0, 1'b0};
			G_P2C: op = '{33'(item_q.pos_z), 33'(item_q.pos_z), 7'd0, 1'b0};
			G_M2A: op = '{33'(item_q.mom_x), 33'(item_q.mom_x), 7'd0, 1'b1};
			G_M2B: op = '{33'(item_q.mom_y), 33'(item_q.mom_y), 7'd0, 1'b0};
			G_M2C: op = '{33'(item_q.mom_z), 33'(item_q.mom_z), 7'd0, 1'b0};
			G_DTA: op = '{33'(item_q.pos_x), 33'(item_q.mom_x), 7'd0, 1'b1};
			G_DTB: op = '{33'(item_q.pos_y), 33'(item_q.mom_y), 7'd0, 1'b0};
			G_DTC: op = '{33'(item_q.pos_z), 33'(item_q.mom_z), 7'd0, 1'b0};
			G_DDA: op = '{z33(ad_q[31:0]), z33(ad_q[31:0]), 7'd0, 1'b1};
			// cross term counted twice through the extra shift
			G_DDB: op = '{z33(ad_q[31:0]), z33(32'(ad_q[47:32])), 7'd33, 1'b0};
			G_DDC: op = '{z33(32'(ad_q[47:32])), z33(32'(ad_q[47:32])), 7'd64, 1'b0};
			G_PMA: op = '{z33(p2_q[31:0]), z33(m2_q[31:0]), 7'd0, 1'b1};
			G_PMB: op = '{z33(p2_q[31:0]), z33(32'(m2_q[47:32])), 7'd32, 1'b0};
			G_PMC: op = '{z33(32'(p2_q[47:32])), z33(m2_q[31:0]), 7'd32, 1'b0};
			G_PMD: op = '{z33(32'(p2_q[47:32])), z33(32'(m2_q[47:32])), 7'd64, 1'b0};
			G_KA:  op = '{z33(pm_q[31:0]), z33(thr), 7'd0, 1'b1};
			G_KB:  op = '{z33(pm_q[63:32]), z33(thr), 7'd32, 1'b0};
			G_KC:  op = '{z33(pm_q[95:64]), z33(thr), 7'd64, 1'b0};
			default: op = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			G_IDLE: if (in_valid) state_d = eligible ? G_LO : G_DONE;
			G_LO:   state_d = G_HI;
			G_HI:   state_d = G_P2A;
			G_P2A:  state_d = G_P2B;
			G_P2B:  state_d = G_P2C;
			G_P2C:  state_d = G_M2A;
			G_M2A:  state_d = G_M2B;
			G_M2B:  state_d = G_M2C;
			G_M2C:  state_d = reject ? G_DONE : G_DTA;
			G_DTA:  state_d = G_DTB;
			G_DTB:  state_d = G_DTC;
			G_DTC:  state_d = G_DDA;
			G_DDA:  state_d = G_DDB;
			G_DDB:  state_d = G_DDC;
			G_DDC:  state_d = G_PMA;
			G_PMA:  state_d = G_PMB;
			G_PMB:  state_d = G_PMC;
			G_PMC:  state_d = G_PMD;
			G_PMD:  state_d = G_KA;
			G_KA:   state_d = G_KB;
			G_KB:   state_d = G_KC;
			G_KC:   state_d = (cmp_le && k_q != AW'(NUM_BINS - 1)) ? G_KA : G_DONE;
			G_DONE: if (res_ready) state_d = G_IDLE;
			default: state_d = G_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == G_IDLE);
		res_valid = (state_q == G_DONE);
		res.hit = hit_q;
		res.bin = BIN_W'(bin_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= G_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		acc_q <= acc_next;
		unique case (state_q)
			G_IDLE: begin
				item_q <= item;
				hit_q <= 1'b0;
				bin_q <= '0;
				k_q <= AW'(1);
			end
			G_LO:  lo2_q <= acc_next[47:0];
			G_HI:  hi2_q <= acc_next[47:0];
			G_P2C: p2_q <= acc_next[47:0];
			G_M2C: begin
				m2_q <= acc_next[47:0];
				hit_q <= !reject;
			end
			G_DTC: ad_q <= dot_v[48] ? dot_neg[47:0] : dot_v[47:0];
			G_DDC: d_q <= acc_next[95:0];
			G_PMD: pm_q <= acc_next[95:0];
			G_KC: begin
				if (cmp_le) begin
					bin_q <= k_q;
					k_q <= k_q + AW'(1);
				end
			end
			default: ;
		endcase
	end

	`SCAH_NEVER(a_k_zero_step, (state_q == G_KA) && (k_q == '0), "bin step with zero index")
	`SCAH_ASSERT(a_fail_ends, (state_q == G_KC) && !cmp_le |=> (state_q == G_DONE),
		"binning did not stop on a failed threshold")

endmodule

// ===== rtl/core/scah_hist.sv =====
// bin count memory with read-modify-write update and histogram dump
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scah_hist import scah_pkg::*; #(
	parameter int NUM_BINS = NUM_BINS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [23:0]      report_period,
	input  logic             res_valid,
	output logic             res_ready,
	input  res_t             res,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [BIN_W-1:0] out_index,
	output logic [31:0]      out_count,
	output logic [31:0]      out_peak,
	output logic             out_last
);

	localparam int AW = $clog2(NUM_BINS);

	hist_state_t state_q, state_d;
	logic [NUM_BINS-1:0] vld_q;
	logic [31:0] peak_q;
	logic [23:0] pc_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] bin_q;
	logic [31:0] out_count_q;

	logic ram_we, ram_re;
	logic [AW-1:0] ram_raddr;
	logic [31:0] ram_rdata;
	logic [31:0] cur, inc;
	logic [23:0] pc_inc;
	logic dump;
	logic is_last;

	scah_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (bin_q),
		.wdata (inc),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// never-written bins read as zero
	assign cur = vld_q[bin_q] ? ram_rdata : 32'd0;
	assign inc = (cur == 32'hFFFF_FFFF) ? cur : cur + 32'd1;
	assign pc_inc = pc_q + 24'd1;
	// a period of zero dumps on every hit
	assign dump = !(pc_inc < report_period && pc_inc != 24'd0);
	assign is_last = (idx_q == AW'(NUM_BINS - 1));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			H_IDLE:  if (res_valid && res.hit) state_d = H_RMW;
			H_RMW:   state_d = dump ? H_DRD : H_IDLE;
			H_DRD:   state_d = H_DCAP;
			H_DCAP:  state_d = H_DWAIT;
			H_DWAIT: if (out_ready) state_d = is_last ? H_IDLE : H_DRD;
			default: state_d = H_IDLE;
		endcase
	end

	always_comb begin
		res_ready = (state_q == H_IDLE);
		ram_re = (state_q == H_IDLE && res_valid && res.hit) || (state_q == H_DRD);
		ram_raddr = (state_q == H_DRD) ? idx_q : res.bin[AW-1:0];
		ram_we = (state_q == H_RMW);
		out_valid = (state_q == H_DWAIT);
		out_index = BIN_W'(idx_q);
		out_count = out_count_q;
		out_peak = peak_q;
		out_last = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
			vld_q <= '0;
			peak_q <= '0;
			pc_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == H_RMW) begin
				vld_q[bin_q] <= 1'b1;
				if (inc > peak_q)
					peak_q <= inc;
				pc_q <= dump ? 24'd0 : pc_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			H_IDLE: begin
				bin_q <= res.bin[AW-1:0];
				idx_q <= '0;
			end
			H_DCAP: out_count_q <= vld_q[idx_q] ? ram_rdata : 32'd0;
			H_DWAIT: if (out_ready && !is_last) idx_q <= idx_q + AW'(1);
			default: ;
		endcase
	end

	`SCAH_ASSERT(a_peak_bound, out_valid |-> (out_count_q <= peak_q),
		"reported bin count above peak")
	`SCAH_ASSERT(a_dump_ends, out_valid && out_ready && out_last |=> (state_q == H_IDLE),
		"dump did not end after final bin")
	`SCAH_ASSERT(a_write_marks, ram_we |=> vld_q[$past(bin_q)],
		"written bin not marked valid")

endmodule

// ===== tb/sv/angle_hist_checker.sv =====
// checker for the angle histogram core: predicts dumps from accepted steps and compares them
`timescale 1ns / 1ps
module angle_hist_checker import scah_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [23:0]  cfg_wdata,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [143:0] s_tdata,
	input  logic         s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [71:0]  m_tdata,
	input  logic         m_tlast,
	output int           fail_count,
	output int           pending
);

	localparam int NBINS = NUM_BINS_DEF;

	typedef struct {
		logic [5:0]  idx;
		logic [31:0] cnt;
		logic [31:0] peak;
		logic        last;
	} bin_report_t;

	bin_report_t expected_bins[$];

	logic [31:0] cos_sq_limit[NBINS];
	logic [1:0]  mode;
	logic [22:0] radius;
	logic [15:0] tol;
	logic [23:0] period;
	logic [31:0] hist[NBINS];
	logic [31:0] hits_total;
	logic [31:0] peak;
	logic [23:0] hits_in_period;

	function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] w;
		w = 128'(a) * 128'(b);
		return w[123:60];
	endfunction

	// cos^2 of the lower edge of bin k, unsigned Q32
	function automatic logic [31:0] edge_cos_sq(input int k);
		logic [127:0] w;
		logic [63:0] theta, x2, term, c, c2;
		logic signed [65:0] acc;
		logic [64:0] t;
		w = (128'(HALF_PI_Q60) * 128'(k)) / NBINS;
		theta = w[63:0];
		x2 = q60_product(theta, theta);
		term = ONE_Q60;
		acc = $signed({2'b00, ONE_Q60});
		for (int n = 1; n <= 12; n++) begin
			term = q60_product(term, x2) / 64'((2 * n - 1) * (2 * n));
			if (n % 2 == 1)
				acc = acc - $signed({2'b00, term});
			else
				acc = acc + $signed({2'b00, term});
		end
		c = (acc < 0) ? 64'd0 : acc[63:0];
		if (c > ONE_Q60)
			c = ONE_Q60;
		c2 = q60_product(c, c);
		t = ({1'b0, c2} + 65'd134217728) >> 28;
		return (t > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// one accepted step: update the histogram and queue a dump when the period is reached
	task automatic tally_step(input logic [143:0] d, input logic boundary);
		longint px, py, pz, mx, my, mz, p2, m2, dot, lo_edge, lo2, hi2;
		logic [127:0] lhs, rhs;
		int b;
		bin_report_t r;
		if (mode != MODE_IN_OUT && mode != MODE_IN_ONLY)
			return;
		if (!boundary)
			return;
		px = longint'($signed(d[23:0]));
		py = longint'($signed(d[47:24]));
		pz = longint'($signed(d[71:48]));
		mx = longint'($signed(d[95:72]));
		my = longint'($signed(d[119:96]));
		mz = longint'($signed(d[143:120]));
		p2 = px * px + py * py + pz * pz;
		m2 = mx * mx + my * my + mz * mz;
		if (p2 == 0 || m2 == 0)
			return;
		lo_edge = longint'(radius) - longint'(tol);
		if (lo_edge < 0)
			lo_edge = -lo_edge;
		lo2 = lo_edge * lo_edge;
		hi2 = (longint'(radius) + longint'(tol)) * (longint'(radius) + longint'(tol));
		if (!(p2 > lo2 && p2 < hi2))
			return;
		dot = px * mx + py * my + pz * mz;
		if (dot < 0)
			dot = -dot;
		lhs = (128'(dot) * 128'(dot)) << 32;
		b = 0;
		for (int k = 1; k < NBINS; k++) begin
			rhs = 128'(p2) * 128'(m2) * 128'(cos_sq_limit[k]);
			if (lhs <= rhs)
				b++;
		end
		if (hist[b] != 32'hFFFF_FFFF)
			hist[b]++;
		if (hist[b] > peak)
			peak = hist[b];
		if (hits_total != 32'hFFFF_FFFF)
			hits_total++;
		hits_in_period = hits_in_period + 24'd1;
		if (hits_in_period < period && hits_in_period != 0)
			return;
		hits_in_period = '0;
		for (int i = 0; i < NBINS; i++) begin
			r.idx = 6'(i);
			r.cnt = hist[i];
			r.peak = peak;
			r.last = (i == NBINS - 1);
			expected_bins = {expected_bins, r};
		end
	endtask

	initial begin
		for (int k = 0; k < NBINS; k++)
			cos_sq_limit[k] = (k == 0) ? 32'hFFFF_FFFF : edge_cos_sq(k);
	end

	always @(posedge clk or negedge arst_n) begin
		bin_report_t e;
		if (!arst_n) begin
			mode <= MODE_IN_OUT;
			radius <= 23'd1000000;
			tol <= 16'd1;
			period <= 24'd100000;
			for (int i = 0; i < NBINS; i++)
				hist[i] = '0;
			hits_total = '0;
			peak = '0;
			hits_in_period = '0;
			expected_bins.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ACCEPT_MODE:   mode <= cfg_wdata[1:0];
					REG_OUTER_RADIUS:  radius <= cfg_wdata[22:0];
					REG_SURFACE_TOL:   tol <= cfg_wdata[15:0];
					REG_REPORT_PERIOD: period <= cfg_wdata[23:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				tally_step(s_tdata, s_tuser);
			if (m_tvalid && m_tready) begin
				if (expected_bins.size() == 0) begin
					report_mismatch("unexpected bin_index", 32'(m_tdata[5:0]), 32'd0);
				end else begin
					e = expected_bins.pop_front();
					if (m_tdata[5:0] != e.idx)
						report_mismatch("bin_index", 32'(m_tdata[5:0]), 32'(e.idx));
					if (m_tdata[37:6] != e.cnt)
						report_mismatch("bin_count", m_tdata[37:6], e.cnt);
					if (m_tdata[69:38] != e.peak)
						report_mismatch("peak_count", m_tdata[69:38], e.peak);
					if (m_tlast != e.last)
						report_mismatch("last", 32'(m_tlast), 32'(e.last));
				end
			end
			pending <= expected_bins.size();
		end
	end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for the angle histogram core: clock, reset, stimulus, flow control, verdict
`timescale 1ns / 1ps
module tb;
	import scah_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 100;

	logic         clk;
	logic         arst_n;
	logic         cfg_we;
	logic [1:0]   cfg_index;
	logic [23:0]  cfg_wdata;
	logic         s_tvalid;
	logic         s_tready;
	// pos_x, pos_y, pos_z, mom_x, mom_y, mom_z
	logic [143:0] s_tdata;
	// on_boundary
	logic         s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	// bin_index, bin_count, peak_count, two zero bits
	logic [71:0]  m_tdata;
	logic         m_tlast;

	int fail_count;
	int pending;
	int send_idle_pct;
	int recv_idle_pct;
	int dumps_seen;
	int quiet_cycles;
	bit hold_req;

	sphere_crossing_angle_histogram_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	angle_hist_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// output side flow control, with one long hold-off on request
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct);
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready && m_tlast)
			dumps_seen++;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_step(input item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.on_boundary;
		s_tdata <= {it.mom_z, it.mom_y, it.mom_x, it.pos_z, it.pos_y, it.pos_x};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// stop offering, wait for all dumps, then let a step that makes no dump finish
	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_registers(input logic [1:0] mode, input int radius, input int tol,
			input int period);
		cfg_we <= 1'b1;
		cfg_index <= REG_ACCEPT_MODE;
		cfg_wdata <= 24'(mode);
		@(posedge clk);
		cfg_index <= REG_OUTER_RADIUS;
		cfg_wdata <= 24'(radius);
		@(posedge clk);
		cfg_index <= REG_SURFACE_TOL;
		cfg_wdata <= 24'(tol);
		@(posedge clk);
		cfg_index <= REG_REPORT_PERIOD;
		cfg_wdata <= 24'(period);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic item_t make_step(input bit boundary, input int px, input int py,
			input int pz, input int mx, input int my, input int mz);
		item_t it;
		it.on_boundary = boundary;
		it.pos_x = 24'(px);
		it.pos_y = 24'(py);
		it.pos_z = 24'(pz);
		it.mom_x = 24'(mx);
		it.mom_y = 24'(my);
		it.mom_z = 24'(mz);
		return it;
	endfunction

	function automatic int rand24;
		return int'($signed(24'($urandom)));
	endfunction

	// a step on a sphere of the given radius with assorted momenta, or plain noise
	function automatic item_t random_step(input int r);
		int px, py, pz, lim, mx, my, mz, pick, rr;
		real rem;
		item_t it;
		if ($urandom_range(99) < 15 || r <= 0)
			return make_step($urandom_range(1), rand24(), rand24(), rand24(),
				rand24(), rand24(), rand24());
		rr = r;
		// sometimes a point well inside the sphere, which misses the band unless tol exceeds half the radius
		if ($urandom_range(99) < 5)
			rr = r / 2;
		px = $urandom_range(2 * rr) - rr;
		lim = $rtoi($sqrt(real'(rr) * rr - real'(px) * px));
		py = $urandom_range(2 * lim) - lim;
		rem = real'(rr) * rr - real'(px) * px - real'(py) * py;
		pz = $rtoi($sqrt(rem < 0.0 ? 0.0 : rem) + 0.5);
		if ($urandom_range(1))
			pz = -pz;
		pick = $urandom_range(9);
		case (pick)
			0: begin mx = px; my = py; mz = pz; end
			1: begin mx = -px; my = -py; mz = -pz; end
			2: begin mx = py; my = -px; mz = 0; end
			3: begin
				mx = $urandom_range(200) - 100;
				my = $urandom_range(200) - 100;
				mz = $urandom_range(200) - 100;
			end
			default: begin mx = rand24(); my = rand24(); mz = rand24(); end
		endcase
		it = make_step($urandom_range(99) < 95, px, py, pz, mx, my, mz);
		return it;
	endfunction

	initial begin
		int radius, tol, items;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ACCEPT_MODE;
		cfg_wdata = '0;
		send_idle_pct = 18;
		recv_idle_pct = 59;
		dumps_seen = 0;
		quiet_cycles = 0;
		hold_req = 1'b0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// small sphere, dump every third hit
		set_registers(MODE_IN_OUT, 1000, 20, 3);
		send_step(make_step(1, 1000, 0, 0, 500, 0, 0));
		send_step(make_step(1, 0, 1000, 0, 0, -7, 0));
		send_step(make_step(1, 0, 0, 1000, 1, 0, 0));
		send_step(make_step(1, 600, 800, 0, 800, -600, 0));
		send_step(make_step(1, 600, 800, 0, 600, 801, 3));
		send_step(make_step(1, 980, 0, 0, 1, 1, 1));
		send_step(make_step(1, 1020, 0, 0, 1, 1, 1));
		send_step(make_step(1, 981, 0, 0, 1, 2, 3));
		send_step(make_step(1, 0, 0, 0, 1, 2, 3));
		send_step(make_step(1, 1000, 0, 0, 0, 0, 0));
		send_step(make_step(0, 1000, 0, 0, 1, 0, 0));
		send_step(make_step(1, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
		send_step(make_step(1, 577, -577, 577, -8388608, 8388607, -8388608));
		send_step(make_step(1, -707, 707, 0, 1, 1, 0));
		drain();

		// largest radius and band, dump on every hit
		set_registers(MODE_IN_ONLY, 8388607, 65535, 1);
		send_step(make_step(1, -8388608, 0, 0, -8388608, -8388608, -8388608));
		send_step(make_step(1, 0, 8388607, 0, 8388607, 8388607, 8388607));
		send_step(make_step(1, 0, 0, -8388608, 8388607, -8388608, 0));
		send_step(make_step(1, 4843165, 4843165, 4843165, 0, 0, -8388608));
		drain();

		// out only and the unused mode count nothing
		set_registers(2'd2, 1000, 20, 1);
		send_step(make_step(1, 1000, 0, 0, 1, 0, 0));
		send_step(random_step(1000));
		drain();
		set_registers(2'd3, 1000, 20, 1);
		send_step(make_step(1, 0, 1000, 0, 0, 1, 0));
		send_step(random_step(1000));
		drain();

		// band wider than the radius: inner edge comes from tol - R
		set_registers(MODE_IN_OUT, 10, 65535, 2);
		send_step(make_step(1, 65535, 0, 0, 3, 4, 5));
		send_step(make_step(1, 0, 65526, 0, 3, 4, 5));
		send_step(make_step(1, 0, 0, 65525, 3, 4, 5));
		send_step(random_step(65535));
		drain();

		// empty band and longest period
		set_registers(MODE_IN_OUT, 0, 0, 16777215);
		send_step(make_step(1, 1, 0, 0, 1, 0, 0));
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 18 : (phase == 1) ? 59 : 0;
			recv_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 18 : 0;
			radius = ($urandom_range(3) == 0) ? $urandom_range(8388607, 100000)
				: $urandom_range(20000, 50);
			tol = $urandom_range(65535, 2);
			if (tol > radius / 4 && $urandom_range(1))
				tol = radius / 4 + 2;
			set_registers(2'($urandom_range(1)), radius, tol, $urandom_range(4, 1));
			items = 0;
			while (items < 125 || (phase == 2 && dumps_seen < 40 && items < 2000)) begin
				if (phase == 0 && items == 40)
					hold_req = 1'b1;
				send_step(random_step(radius));
				items++;
			end
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
